FILE: design/ntag_pkg.sv
package ntag_pkg;

	// Actions carried by a request
	localparam logic ACT_HELLO = 1'b0;
	localparam logic ACT_PURGE = 1'b1;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AGE_STEP = 8'd1;

	// Width of the counts shown on the result ports
	localparam int unsigned CNT_OUT_W = 5;

	localparam logic [31:0] AGE_MAX = 32'hFFFF_FFFF;

	// One neighbor entry
	typedef struct packed {
		logic [15:0]        node_id;
		logic signed [7:0]  rssi;
		logic [7:0]         battery;
		logic [31:0]        age;
		logic [47:0]        mac;
	} entry_t;

	// Per-cycle command to the cell row
	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctrl_t;

	// What the head unit decided about the entry at cell 0
	typedef struct packed {
		logic match;
		logic remove;
	} head_stat_t;

endpackage

FILE: design/ntag_cell.sv
module ntag_cell #(
	parameter int unsigned IDX = 0,
	parameter int unsigned CW  = 5
) (
	input  logic                clk,
	input  ntag_pkg::cell_ctrl_t ctrl,
	input  logic [CW-1:0]       len,
	input  ntag_pkg::entry_t    nxt,
	input  ntag_pkg::entry_t    tail,
	input  ntag_pkg::entry_t    fresh,
	output ntag_pkg::entry_t    q
);

	localparam logic [CW-1:0] IDX_C = CW'(IDX);
	localparam logic [CW-1:0] NXT_C = CW'(IDX + 1);

	ntag_pkg::entry_t entry_q;

	// Load a new entry at the end, or advance one place toward the head
	always_ff @(posedge clk) begin
		if (ctrl.load && (IDX_C == len)) begin
			entry_q <= fresh;
		end else if (ctrl.shift && (NXT_C < len)) begin
			entry_q <= nxt;
		end else if (ctrl.shift && (NXT_C == len)) begin
			entry_q <= tail;
		end
	end

	assign q = entry_q;

endmodule

FILE: design/ntag_head.sv
module ntag_head (
	input  ntag_pkg::entry_t     cur,
	input  logic                 action,
	input  logic                 found,
	input  logic [15:0]          node_id,
	input  logic signed [7:0]    rssi,
	input  logic [7:0]           battery,
	input  logic [47:0]          mac_address,
	input  logic [31:0]          timeout_ms,
	input  logic [15:0]          age_step_ms,
	output ntag_pkg::entry_t     upd,
	output ntag_pkg::head_stat_t stat
);

	logic [32:0] age_sum;

	assign age_sum = {1'b0, cur.age} + 33'(age_step_ms);

	// Match the first entry with the same id and refresh it, or judge and advance the age on a purge
	always_comb begin
		upd         = cur;
		stat.match  = 1'b0;
		stat.remove = 1'b0;
		if (action == ntag_pkg::ACT_HELLO) begin
			if (!found && (cur.node_id == node_id)) begin
				stat.match  = 1'b1;
				upd.rssi    = rssi;
				upd.battery = battery;
				upd.mac     = mac_address;
				upd.age     = '0;
			end
		end else begin
			stat.remove = (cur.age > timeout_ms);
			upd.age     = age_sum[32] ? ntag_pkg::AGE_MAX : age_sum[31:0];
		end
	end

endmodule

FILE: design/neighbor_table_aging_core.sv
// Channel   Signals                                         Transfer
// -------   ----------------------------------------------  -----------------------
// request   start, busy, action, node_id, rssi, battery,    start high, busy low
//           mac_address
// result    done, hit, inserted, dropped_full,              done high, one cycle
//           removed_count, count_after
// config    cfg_valid, cfg_ready, cfg_index, cfg_data        cfg_valid and cfg_ready
//
// On a transfer the row of cells rotates once through the shared head unit, one entry a
// cycle, then the finish state settles insertion and the result.
// Reset empties the table and restores the register defaults; entry contents are
// not cleared. The result is shown for one cycle and cannot be stalled.
module neighbor_table_aging_core #(
	parameter int unsigned MAX_ENTRIES = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              action,
	input  logic [15:0]                       node_id,
	input  logic signed [7:0]                 rssi,
	input  logic [7:0]                        battery,
	input  logic [47:0]                       mac_address,
	output logic                              done,
	output logic                              hit,
	output logic                              inserted,
	output logic                              dropped_full,
	output logic [ntag_pkg::CNT_OUT_W-1:0]    removed_count,
	output logic [ntag_pkg::CNT_OUT_W-1:0]    count_after,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ntag_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [31:0]                       cfg_data
);

	localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
	localparam logic [CW-1:0] MAX_C = CW'(MAX_ENTRIES);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	state_t state_q;

	logic [31:0]        timeout_q;
	logic [15:0]        age_step_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      steps_q;
	logic [CW-1:0]      removed_q;
	logic               found_q;

	logic               action_q;
	logic [15:0]        node_id_q;
	logic signed [7:0]  rssi_q;
	logic [7:0]         battery_q;
	logic [47:0]        mac_q;

	logic               done_q;
	logic               hit_q;
	logic               inserted_q;
	logic               dropped_q;
	logic [ntag_pkg::CNT_OUT_W-1:0] removed_out_q;
	logic [ntag_pkg::CNT_OUT_W-1:0] count_out_q;

	ntag_pkg::entry_t     cell_q [MAX_ENTRIES];
	ntag_pkg::entry_t     head_upd;
	ntag_pkg::entry_t     fresh;
	ntag_pkg::head_stat_t head_stat;
	ntag_pkg::cell_ctrl_t ctrl;

	logic               accept;
	logic               do_insert;
	logic [CW-1:0]      count_fin;
	logic [CW+4:0]      count_ext;
	logic [CW+4:0]      removed_ext;

	assign accept    = start && (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	// Configuration registers; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q  <= 32'd5000;
			age_step_q <= 16'd1000;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ntag_pkg::REG_TIMEOUT:  timeout_q  <= cfg_data;
				ntag_pkg::REG_AGE_STEP: age_step_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Hold the request fields for the whole rotation
	always_ff @(posedge clk) begin
		if (accept) begin
			action_q  <= action;
			node_id_q <= node_id;
			rssi_q    <= rssi;
			battery_q <= battery;
			mac_q     <= mac_address;
		end
	end

	// Head unit works on the entry at cell 0
	ntag_head u_head (
		.cur         (cell_q[0]),
		.action      (action_q),
		.found       (found_q),
		.node_id     (node_id_q),
		.rssi        (rssi_q),
		.battery     (battery_q),
		.mac_address (mac_q),
		.timeout_ms  (timeout_q),
		.age_step_ms (age_step_q),
		.upd         (head_upd),
		.stat        (head_stat)
	);

	assign fresh.node_id = node_id_q;
	assign fresh.rssi    = rssi_q;
	assign fresh.battery = battery_q;
	assign fresh.age     = '0;
	assign fresh.mac     = mac_q;

	// Append a new entry after the scan on a hello when the id was not seen and room is left
	assign do_insert = (state_q == ST_FIN) && (action_q == ntag_pkg::ACT_HELLO) &&
		!found_q && (count_q < MAX_C);
	assign count_fin = do_insert ? (count_q + CW'(1)) : count_q;

	assign ctrl.shift = (state_q == ST_SCAN);
	assign ctrl.load  = do_insert;

	// Row of cells; the last cell's neighbor is the head unit's output
	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		ntag_pkg::entry_t nxt;
		if (i == MAX_ENTRIES - 1) begin : g_last
			assign nxt = head_upd;
		end else begin : g_mid
			assign nxt = cell_q[i+1];
		end
		ntag_cell #(
			.IDX (i),
			.CW  (CW)
		) u_cell (
			.clk   (clk),
			.ctrl  (ctrl),
			.len   (count_q),
			.nxt   (nxt),
			.tail  (head_upd),
			.fresh (fresh),
			.q     (cell_q[i])
		);
	end

	// Sequence: rotate once through the head, then settle the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			steps_q   <= '0;
			removed_q <= '0;
			found_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						steps_q   <= count_q;
						removed_q <= '0;
						found_q   <= 1'b0;
						state_q   <= (count_q == '0) ? ST_FIN : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (head_stat.match) begin
						found_q <= 1'b1;
					end
					if (head_stat.remove) begin
						count_q   <= count_q - CW'(1);
						removed_q <= removed_q + CW'(1);
					end
					steps_q <= steps_q - CW'(1);
					if (steps_q == CW'(1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					count_q <= count_fin;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign count_ext   = (CW+5)'(count_fin);
	assign removed_ext = (CW+5)'(removed_q);

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_FIN);
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_FIN) begin
			hit_q         <= (action_q == ntag_pkg::ACT_HELLO) && found_q;
			inserted_q    <= do_insert;
			dropped_q     <= (action_q == ntag_pkg::ACT_HELLO) && !found_q &&
				(count_q == MAX_C);
			removed_out_q <= removed_ext[ntag_pkg::CNT_OUT_W-1:0];
			count_out_q   <= count_ext[ntag_pkg::CNT_OUT_W-1:0];
		end
	end

	assign done          = done_q;
	assign hit           = hit_q;
	assign inserted      = inserted_q;
	assign dropped_full  = dropped_q;
	assign removed_count = removed_out_q;
	assign count_after   = count_out_q;

endmodule

FILE: design/ntag_checker.sv
module ntag_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           start,
	input logic                           busy,
	input logic                           done,
	input logic                           hit,
	input logic                           inserted,
	input logic                           dropped_full,
	input logic [ntag_pkg::CNT_OUT_W-1:0] removed_count
);

	// A transfer makes the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request transfer did not raise busy");

	// The result comes out after the work has ended
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// One strobe per item
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	// A result reports at most one hello outcome class, and a hello reports no removals
	a_hello_flags: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $onehot0({hit, inserted, dropped_full}))
		else $error("more than one hello outcome");

	a_hello_no_remove: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (hit || inserted || dropped_full)) |-> (removed_count == '0))
		else $error("hello result reports removed entries");

endmodule

bind neighbor_table_aging_core ntag_checker u_ntag_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.hit           (hit),
	.inserted      (inserted),
	.dropped_full  (dropped_full),
	.removed_count (removed_count)
);
